### hw/rtl/bca_pkg.sv
// Shared types, constants and state encoding for the barometric compensation block.
`timescale 1ns / 1ps
package bca_pkg;

    localparam int unsigned AVG_DEPTH_DEF = 32;
    localparam logic [16:0] RING_RESET = 17'd101325;
    localparam logic [16:0] PRESS_MAX  = 17'd131071;

    localparam logic [1:0] REG_PCA = 2'd0;
    localparam logic [1:0] REG_PCB = 2'd1;
    localparam logic [1:0] REG_TC  = 2'd2;
    localparam logic [1:0] REG_OSS = 2'd3;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [23:0] raw_pressure;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic [16:0]        pressure_pa;
        logic [16:0]        average_pa;
        logic               divide_error;
    } t_out_beat;

    // Sequencer steps: idle, multiplies, adds/shifts, serial divisions, ring read/update and output.
    typedef enum logic [4:0] {
        S_IDLE, S_X1M, S_X1S, S_DEN, S_TDIV, S_TDW, S_B5, S_SQM, S_SQ,
        S_X1B2, S_X2AC2, S_B3, S_X1AC3, S_X2B1, S_X3, S_B4M, S_B4,
        S_B7, S_PDIV, S_PDW, S_P1, S_P2, S_P3, S_P4, S_PF,
        S_RRD, S_RUPD, S_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic        is_signed;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quo;
    } t_div_rsp;

endpackage

### hw/rtl/bca_div.sv
// Serial 32-bit divider, one quotient bit per cycle, signed or unsigned.
`timescale 1ns / 1ps
module bca_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bca_pkg::t_div_req i_req,
    output bca_pkg::t_div_rsp o_rsp
);
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_q, n_q;
    logic [31:0] r_d, n_d;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic        r_neg, n_neg;
    logic [32:0] w_trial;
    logic [31:0] w_rem_sh;

    always_comb begin
        n_rem = r_rem; n_q = r_q; n_d = r_d; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0; n_neg = r_neg;
        w_rem_sh = {r_rem[30:0], r_q[31]};
        w_trial  = {1'b0, w_rem_sh} - {1'b0, r_d};
        if (i_req.start) begin
            n_neg  = i_req.is_signed & (i_req.num[31] ^ i_req.den[31]);
            n_q    = (i_req.is_signed && i_req.num[31]) ? 32'(-i_req.num) : i_req.num;
            n_d    = (i_req.is_signed && i_req.den[31]) ? 32'(-i_req.den) : i_req.den;
            n_rem  = '0;
            n_cnt  = 6'd32;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[32] || r_rem[31]) begin
                n_rem = 32'(w_trial);
                n_q   = {r_q[30:0], 1'b1};
            end else begin
                n_rem = w_rem_sh;
                n_q   = {r_q[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_q   <= n_q;
        r_d   <= n_d;
        r_neg <= n_neg;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? 32'(-r_q) : r_q;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without busy");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_done) else $error("divider busy and done together");
    a_cnt_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_cnt == 6'd0)
        else $error("divider count");
endmodule

### hw/rtl/bca_ring.sv
// Pressure history ring with running sum and a clearing pass after reset.
`timescale 1ns / 1ps
module bca_ring #(
    parameter int unsigned AVG_DEPTH = bca_pkg::AVG_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rd,
    input  logic        i_wr,
    input  logic [16:0] i_press,
    output logic        o_clearing,
    output logic [16:0] o_average
);
    localparam int unsigned AW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int unsigned SW = 17 + $clog2(AVG_DEPTH + 1);

    logic [16:0]   mem [AVG_DEPTH];
    logic [16:0]   r_old;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [AW:0]   r_clr, n_clr;
    logic [SW-1:0] r_sum, n_sum;

    assign o_clearing = (r_clr != '0);

    always_comb begin
        n_ptr = r_ptr;
        n_clr = r_clr;
        n_sum = r_sum;
        if (o_clearing) begin
            n_clr = r_clr - 1'b1;
        end else if (i_wr) begin
            n_sum = r_sum - SW'(r_old) + SW'(i_press);
            n_ptr = (r_ptr == AW'(AVG_DEPTH - 1)) ? '0 : r_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_clearing) begin
            mem[AW'(r_clr - 1'b1)] <= bca_pkg::RING_RESET;
        end else if (i_wr) begin
            mem[r_ptr] <= i_press;
        end
        if (i_rd) begin
            r_old <= mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_clr <= (AW+1)'(AVG_DEPTH);
            r_sum <= SW'(AVG_DEPTH) * SW'(bca_pkg::RING_RESET);
        end else begin
            r_ptr <= n_ptr;
            r_clr <= n_clr;
            r_sum <= n_sum;
        end
    end

    assign o_average = 17'(r_sum / AVG_DEPTH);

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= AW'(AVG_DEPTH - 1)) else $error("ring pointer out of range");
    a_no_wr_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clearing |-> !i_wr) else $error("ring write during clear");
    a_ptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr && !o_clearing) |=> r_ptr != $past(r_ptr)) else $error("pointer stuck");
endmodule

### hw/rtl/baro_compensate_avg.sv
// Top level: config registers, compensation sequencer with shared multiplier, output beat.
`timescale 1ns / 1ps
// One beat in, one beat out. A normal beat goes from acceptance to o_valid through 23
// sequencer steps using one shared 32x32 multiplier and adder, plus two serial
// divisions (temperature and pressure), each a start step and a wait on the divider.
// A zero temperature divisor ends the run after the divisor step, a zero pressure
// divisor after the B4 step. The output is held in a register until taken and no beat
// is accepted meanwhile, so a new beat is taken only once the last one is through.
// After reset a clearing pass fills the averaging ring with 101325 Pa, during which
// no beat is accepted. Config writes are only legal while idle.
module baro_compensate_avg #(
    parameter int unsigned AVG_DEPTH = bca_pkg::AVG_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  bca_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output bca_pkg::t_out_beat o_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    bca_pkg::t_state r_st, n_st;
    logic [63:0] r_pca, r_tc;
    logic [31:0] r_pcb;
    logic [1:0]  r_oss;
    logic [1:0]  w_idx;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:3];
    assign w_wr   = psel && penable && pwrite && (paddr[2:0] == 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pca <= '0; r_pcb <= '0; r_tc <= '0; r_oss <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                bca_pkg::REG_PCA: r_pca <= pwdata;
                bca_pkg::REG_PCB: r_pcb <= pwdata[31:0];
                bca_pkg::REG_TC:  r_tc  <= pwdata;
                bca_pkg::REG_OSS: r_oss <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            bca_pkg::REG_PCA: prdata = r_pca;
            bca_pkg::REG_PCB: prdata = {32'd0, r_pcb};
            bca_pkg::REG_TC:  prdata = r_tc;
            bca_pkg::REG_OSS: prdata = {62'd0, r_oss};
            default:          prdata = '0;
        endcase
    end

    logic [31:0] ac1, ac2, ac3, ac4, b1, b2, ac5, ac6, mc, md;
    assign ac1 = {{16{r_pca[63]}}, r_pca[63:48]};
    assign ac2 = {{16{r_pca[47]}}, r_pca[47:32]};
    assign ac3 = {{16{r_pca[31]}}, r_pca[31:16]};
    assign ac4 = {16'd0, r_pca[15:0]};
    assign b1  = {{16{r_pcb[31]}}, r_pcb[31:16]};
    assign b2  = {{16{r_pcb[15]}}, r_pcb[15:0]};
    assign ac5 = {16'd0, r_tc[63:48]};
    assign ac6 = {16'd0, r_tc[47:32]};
    assign mc  = {{16{r_tc[31]}}, r_tc[31:16]};
    assign md  = {{16{r_tc[15]}}, r_tc[15:0]};

    // working registers
    logic [31:0] r_ut, r_up, r_m, r_x1, r_x2, r_b6, r_sq, r_b3, r_b4, r_b7, r_p;
    logic [31:0] r_t;
    logic        r_err, r_tzero;
    logic [16:0] r_press;
    bca_pkg::t_out_beat r_out;
    logic        r_ovalid;

    // shared multiplier, low 32 bits (wraps as in 32-bit arithmetic)
    logic [31:0] w_ma, w_mb, w_mp;
    assign w_mp = w_ma * w_mb;

    bca_pkg::t_div_req w_dreq;
    bca_pkg::t_div_rsp w_drsp;
    bca_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    logic w_rd, w_wrr, w_clearing;
    logic [16:0] w_avg;
    bca_ring #(.AVG_DEPTH(AVG_DEPTH)) u_ring (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_rd(w_rd), .i_wr(w_wrr),
        .i_press(r_press), .o_clearing(w_clearing), .o_average(w_avg)
    );

    function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
        asr = 32'($signed(v) >>> n);
    endfunction

    logic [31:0] w_up_sh, w_p_shift, w_sum3, w_b3pre;
    assign w_up_sh  = {8'd0, i_data.raw_pressure} >> (4'd8 - {2'd0, r_oss});
    assign w_sum3   = r_x1 + r_x2;
    assign w_b3pre  = (((ac1 << 2) + w_sum3) << r_oss) + 32'd2;
    assign w_p_shift = r_b7[31] ? {r_p[30:0], 1'b0} : r_p;

    assign o_ready = (r_st == bca_pkg::S_IDLE) && !r_ovalid && !w_clearing;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            bca_pkg::S_IDLE:  if (i_valid && o_ready) n_st = bca_pkg::S_X1M;
            bca_pkg::S_X1M:   n_st = bca_pkg::S_X1S;
            bca_pkg::S_X1S:   n_st = bca_pkg::S_DEN;
            bca_pkg::S_DEN:   n_st = r_tzero ? bca_pkg::S_OUT : bca_pkg::S_TDIV;
            bca_pkg::S_TDIV:  n_st = bca_pkg::S_TDW;
            bca_pkg::S_TDW:   if (w_drsp.done) n_st = bca_pkg::S_B5;
            bca_pkg::S_B5:    n_st = bca_pkg::S_SQM;
            bca_pkg::S_SQM:   n_st = bca_pkg::S_SQ;
            bca_pkg::S_SQ:    n_st = bca_pkg::S_X1B2;
            bca_pkg::S_X1B2:  n_st = bca_pkg::S_X2AC2;
            bca_pkg::S_X2AC2: n_st = bca_pkg::S_B3;
            bca_pkg::S_B3:    n_st = bca_pkg::S_X1AC3;
            bca_pkg::S_X1AC3: n_st = bca_pkg::S_X2B1;
            bca_pkg::S_X2B1:  n_st = bca_pkg::S_X3;
            bca_pkg::S_X3:    n_st = bca_pkg::S_B4M;
            bca_pkg::S_B4M:   n_st = bca_pkg::S_B4;
            bca_pkg::S_B4:    n_st = (r_m[31:15] == 17'd0) ? bca_pkg::S_OUT : bca_pkg::S_B7;
            bca_pkg::S_B7:    n_st = bca_pkg::S_PDIV;
            bca_pkg::S_PDIV:  n_st = bca_pkg::S_PDW;
            bca_pkg::S_PDW:   if (w_drsp.done) n_st = bca_pkg::S_P1;
            bca_pkg::S_P1:    n_st = bca_pkg::S_P2;
            bca_pkg::S_P2:    n_st = bca_pkg::S_P3;
            bca_pkg::S_P3:    n_st = bca_pkg::S_P4;
            bca_pkg::S_P4:    n_st = bca_pkg::S_PF;
            bca_pkg::S_PF:    n_st = bca_pkg::S_RRD;
            bca_pkg::S_RRD:   n_st = bca_pkg::S_RUPD;
            bca_pkg::S_RUPD:  n_st = bca_pkg::S_OUT;
            bca_pkg::S_OUT:   n_st = bca_pkg::S_IDLE;
            default:          n_st = bca_pkg::S_IDLE;
        endcase
    end

    // multiplier operand selection, divider requests and ring read/write strobes
    always_comb begin
        w_ma = r_m; w_mb = 32'd1;
        w_dreq = '0;
        w_rd = 1'b0; w_wrr = 1'b0;
        unique case (r_st)
            bca_pkg::S_X1M:   begin w_ma = r_ut - ac6; w_mb = ac5; end
            bca_pkg::S_SQM:   begin w_ma = r_b6; w_mb = r_b6; end
            bca_pkg::S_X1B2:  begin w_ma = b2; w_mb = r_sq; end
            bca_pkg::S_X2AC2: begin w_ma = ac2; w_mb = r_b6; end
            bca_pkg::S_X1AC3: begin w_ma = ac3; w_mb = r_b6; end
            bca_pkg::S_X2B1:  begin w_ma = b1; w_mb = r_sq; end
            bca_pkg::S_B4M:   begin w_ma = ac4; w_mb = r_x1 + 32'd32768; end
            bca_pkg::S_B7:    begin w_ma = r_up - r_b3; w_mb = 32'd50000 >> r_oss; end
            bca_pkg::S_P1:    begin w_ma = asr(w_p_shift, 3); w_mb = asr(w_p_shift, 3); end
            bca_pkg::S_P2:    begin w_ma = r_m; w_mb = 32'd3038; end
            bca_pkg::S_P3:    begin w_ma = 32'(-32'sd7357); w_mb = r_p; end
            bca_pkg::S_TDIV:  begin
                w_dreq.start = 1'b1; w_dreq.is_signed = 1'b1;
                w_dreq.num = mc << 11; w_dreq.den = r_x2;
            end
            bca_pkg::S_PDIV:  begin
                w_dreq.start = 1'b1; w_dreq.is_signed = 1'b0;
                w_dreq.num = r_b7[31] ? r_b7 : {r_b7[30:0], 1'b0}; w_dreq.den = r_b4;
            end
            bca_pkg::S_RRD:   w_rd = 1'b1;
            bca_pkg::S_RUPD:  w_wrr = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            bca_pkg::S_IDLE: if (i_valid && o_ready) begin
                r_ut <= {16'd0, i_data.raw_temperature};
                r_up <= w_up_sh;
                r_err <= 1'b0; r_press <= '0; r_t <= '0;
            end
            bca_pkg::S_X1M:   r_m <= w_mp;
            bca_pkg::S_X1S:   begin r_x1 <= asr(r_m, 15); r_tzero <= (asr(r_m, 15) + md) == 0; end
            bca_pkg::S_DEN:   begin r_x2 <= r_x1 + md; if (r_tzero) r_err <= 1'b1; end
            bca_pkg::S_TDW:   if (w_drsp.done) r_x2 <= w_drsp.quo;
            bca_pkg::S_B5:    begin
                r_t  <= asr(r_x1 + r_x2 + 32'd8, 4);
                r_b6 <= r_x1 + r_x2 - 32'd4000;
            end
            bca_pkg::S_SQM:   r_m <= w_mp;
            bca_pkg::S_SQ:    r_sq <= asr(r_m, 12);
            bca_pkg::S_X1B2:  r_x1 <= asr(w_mp, 11);
            bca_pkg::S_X2AC2: r_x2 <= asr(w_mp, 11);
            bca_pkg::S_B3:    r_b3 <= asr(w_b3pre, 2);
            bca_pkg::S_X1AC3: r_x1 <= asr(w_mp, 13);
            bca_pkg::S_X2B1:  r_x2 <= asr(w_mp, 16);
            bca_pkg::S_X3:    r_x1 <= asr(w_sum3 + 32'd2, 2);
            bca_pkg::S_B4M:   r_m <= w_mp;
            bca_pkg::S_B4:    begin
                r_b4 <= {15'd0, r_m[31:15]};
                if (r_m[31:15] == 17'd0) r_err <= 1'b1;
            end
            bca_pkg::S_B7:    r_b7 <= w_mp;
            bca_pkg::S_PDW:   if (w_drsp.done) r_p <= w_drsp.quo;
            bca_pkg::S_P1:    begin r_p <= w_p_shift; r_m <= w_mp; end
            bca_pkg::S_P2:    r_x1 <= asr(w_mp, 16);
            bca_pkg::S_P3:    r_x2 <= asr(w_mp, 16);
            bca_pkg::S_P4:    r_p <= r_p + asr(w_sum3 + 32'd3791, 4);
            bca_pkg::S_PF:    r_press <= r_p[31] ? 17'd0 :
                                  (r_p[30:17] != 14'd0) ? bca_pkg::PRESS_MAX : r_p[16:0];
            default: ;
        endcase
    end

    logic [15:0] w_tsat;
    assign w_tsat = ($signed(r_t) > 32'sd32767) ? 16'h7FFF :
                    ($signed(r_t) < -32'sd32768) ? 16'h8000 : r_t[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= bca_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == bca_pkg::S_OUT) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
        if (r_st == bca_pkg::S_OUT) begin
            r_out.temperature_tenths <= w_tsat;
            r_out.pressure_pa        <= r_press;
            r_out.average_pa         <= w_avg;
            r_out.divide_error       <= r_err;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != bca_pkg::S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == bca_pkg::S_OUT) |=> o_valid) else $error("result not presented");
    a_err_no_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == bca_pkg::S_RUPD) |-> !r_err) else $error("ring written on error");
endmodule

### tb/sv/baro_compensate_avg_check.sv
// Checker: mirrors config writes, predicts compensated beats and compares output beats.
`timescale 1ns / 1ps
module baro_compensate_avg_check (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                o_ready,
    input  bca_pkg::t_in_beat   i_data,
    input  logic                o_valid,
    input  logic                i_ready,
    input  bca_pkg::t_out_beat  o_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [63:0]         pwdata,
    input  logic                pready,
    output int                  o_pending,
    output int                  o_fails
);

    localparam int DEPTH = 32;

    logic [63:0] coef_a, coef_t;
    logic [31:0] coef_b;
    logic [1:0]  oss;
    logic [16:0] ring [DEPTH];
    logic [31:0] sum;
    int          wr_ix;
    bca_pkg::t_out_beat beats_due [$];
    int          fails;

    assign o_pending = beats_due.size();
    assign o_fails   = fails;

    function automatic logic [31:0] sra(logic [31:0] u, int n);
        return $signed(u) >>> n;
    endfunction

    function automatic logic [31:0] s16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic bca_pkg::t_out_beat compensate(bca_pkg::t_in_beat b);
        logic [31:0] ac1, ac2, ac3, ac4, b1, b2, ac5, ac6, mc, md, ut, up;
        logic [31:0] x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p, press;
        int          num, tmp;
        logic        err;
        bca_pkg::t_out_beat r;
        ac1 = s16(coef_a[63:48]); ac2 = s16(coef_a[47:32]);
        ac3 = s16(coef_a[31:16]); ac4 = {16'd0, coef_a[15:0]};
        b1  = s16(coef_b[31:16]); b2  = s16(coef_b[15:0]);
        ac5 = {16'd0, coef_t[63:48]}; ac6 = {16'd0, coef_t[47:32]};
        mc  = s16(coef_t[31:16]); md  = s16(coef_t[15:0]);
        ut  = {16'd0, b.raw_temperature};
        up  = {8'd0, b.raw_pressure} >> (8 - oss);
        press = 0;
        err = 0;
        tmp = 0;
        x1 = (ut - ac6) * ac5;
        x1 = sra(x1, 15);
        den = x1 + md;
        if (den == 0) begin
            err = 1;
        end else begin
            num = $signed(mc) * 2048;
            x2 = num / $signed(den);
            b5 = x1 + x2;
            tmp = $signed(sra(b5 + 32'd8, 4));
            b6 = b5 - 32'd4000;
            sq = b6 * b6;  sq = sra(sq, 12);
            x1 = b2 * sq;  x1 = sra(x1, 11);
            x2 = ac2 * b6; x2 = sra(x2, 11);
            x3 = x1 + x2;
            b3 = (((ac1 << 2) + x3) << oss) + 32'd2;
            b3 = sra(b3, 2);
            x1 = ac3 * b6; x1 = sra(x1, 13);
            x2 = b1 * sq;  x2 = sra(x2, 16);
            x3 = sra(x1 + x2 + 32'd2, 2);
            b4 = ac4 * (x3 + 32'd32768);
            b4 = b4 >> 15;
            if (b4 == 0) begin
                err = 1;
            end else begin
                b7 = (up - b3) * (32'd50000 >> oss);
                if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
                else p = (b7 / b4) << 1;
                x1 = sra(p, 3);
                x1 = x1 * x1;
                x1 = x1 * 32'd3038; x1 = sra(x1, 16);
                x2 = (32'd0 - 32'd7357) * p; x2 = sra(x2, 16);
                p = p + sra(x1 + x2 + 32'd3791, 4);
                if ($signed(p) < 0) press = 0;
                else if (p > 32'd131071) press = 32'd131071;
                else press = p;
            end
        end
        if (!err) begin
            sum = sum - ring[wr_ix] + press;
            ring[wr_ix] = press[16:0];
            wr_ix = (wr_ix + 1) % DEPTH;
        end
        if (tmp > 32767) tmp = 32767;
        if (tmp < -32768) tmp = -32768;
        r.temperature_tenths = tmp[15:0];
        r.pressure_pa = press[16:0];
        r.average_pa = 17'(sum / DEPTH);
        r.divide_error = err;
        return r;
    endfunction

    initial fails = 0;

    always @(posedge i_clk) begin
        bca_pkg::t_out_beat want;
        if (!i_rst_n) begin
            coef_a = 0; coef_b = 0; coef_t = 0; oss = 0;
            for (int k = 0; k < DEPTH; k++) ring[k] = bca_pkg::RING_RESET;
            sum = 32'(bca_pkg::RING_RESET) * DEPTH;
            wr_ix = 0;
            beats_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:3])
                    bca_pkg::REG_PCA: coef_a = pwdata;
                    bca_pkg::REG_PCB: coef_b = pwdata[31:0];
                    bca_pkg::REG_TC:  coef_t = pwdata;
                    bca_pkg::REG_OSS: oss = pwdata[1:0];
                endcase
            end
            if (i_valid && o_ready) beats_due.push_back(compensate(i_data));
            if (o_valid && i_ready) begin
                if (beats_due.size() == 0) begin
                    $error("output beat with nothing expected");
                    fails++;
                end else begin
                    want = beats_due.pop_front();
                    if (o_data.temperature_tenths !== want.temperature_tenths) begin
                        $error("temperature_tenths exp %0d got %0d",
                               want.temperature_tenths, o_data.temperature_tenths);
                        fails++;
                    end
                    if (o_data.pressure_pa !== want.pressure_pa) begin
                        $error("pressure_pa exp %0d got %0d",
                               want.pressure_pa, o_data.pressure_pa);
                        fails++;
                    end
                    if (o_data.average_pa !== want.average_pa) begin
                        $error("average_pa exp %0d got %0d",
                               want.average_pa, o_data.average_pa);
                        fails++;
                    end
                    if (o_data.divide_error !== want.divide_error) begin
                        $error("divide_error exp %0b got %0b",
                               want.divide_error, o_data.divide_error);
                        fails++;
                    end
                end
            end
        end
    end

endmodule

### tb/sv/baro_compensate_avg_test.sv
// Testbench top: clock, reset, config writes, input beats, output stalls and verdict.
`timescale 1ns / 1ps
module baro_compensate_avg_test;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    bca_pkg::t_in_beat  i_data = '0;
    logic        o_valid;
    logic        i_ready = 0;
    bca_pkg::t_out_beat o_data;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = 0;
    logic [63:0] pwdata = 0;
    logic [63:0] prdata;
    logic        pready;
    int          pending, fails;
    int          send_idle_pct = 0, rx_stall_pct = 0;
    logic        hold_go = 0;
    int          hold_left = 0;

    baro_compensate_avg i_dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data, .o_valid, .i_ready, .o_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    baro_compensate_avg_check i_chk (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data, .o_valid, .i_ready, .o_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_pending(pending), .o_fails(fails)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // long receiver hold-off, counted here so the sender keeps offering beats
    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
        else if (hold_go) hold_left <= 3000;
    end

    always @(posedge i_clk)
        i_ready <= (hold_left > 0) ? 1'b0 : ($urandom_range(99) >= rx_stall_pct);

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    task automatic reg_write(logic [1:0] idx, logic [63:0] val);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic drain_all;
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic set_coeffs(logic [63:0] a, logic [31:0] b, logic [63:0] t, logic [1:0] o);
        drain_all();
        reg_write(bca_pkg::REG_PCA, a);
        reg_write(bca_pkg::REG_PCB, {32'd0, b});
        reg_write(bca_pkg::REG_TC, t);
        reg_write(bca_pkg::REG_OSS, {62'd0, o});
    endtask

    // leaves i_valid high after acceptance; caller lowers it at end of a run
    task automatic send_beat(logic [15:0] ut, logic [23:0] up);
        bca_pkg::t_in_beat b;
        b.raw_temperature = ut;
        b.raw_pressure = up;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid <= 1;
        i_data <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_random(int n);
        logic [15:0] ut;
        logic [23:0] up;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 75) begin
                ut = 16'($urandom_range(20000, 40000));
                up = {16'($urandom_range(15000, 50000)), 8'($urandom)};
            end else begin
                ut = 16'($urandom);
                up = 24'($urandom);
            end
            send_beat(ut, up);
        end
        i_valid <= 0;
    endtask

    function automatic logic [63:0] jitter64(logic [63:0] v);
        return v ^ {6'd0, 10'($urandom), 6'd0, 10'($urandom),
                    6'd0, 10'($urandom), 6'd0, 10'($urandom)};
    endfunction

    // typical calibration set
    localparam logic [63:0] CAL_A = {16'sd408, -16'sd72, -16'sd14383, 16'd32741};
    localparam logic [31:0] CAL_B = {16'sd6190, 16'sd4};
    localparam logic [63:0] CAL_T = {16'd32757, 16'd23153, -16'sd8711, 16'sd2868};

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;

        // all-zero coefficients: temperature divisor zero
        send_beat(16'h0000, 24'h000000);
        send_beat(16'hFFFF, 24'hFFFFFF);
        i_valid <= 0;
        // pressure divisor zero: ac4 of zero
        set_coeffs({CAL_A[63:16], 16'd0}, CAL_B, CAL_T, 2'd0);
        send_beat(16'd27898, 24'h5D2300);
        i_valid <= 0;
        // temperature divisor zero with nonzero mc: ac5 zero and md zero
        set_coeffs(CAL_A, CAL_B, {16'd0, CAL_T[47:16], 16'd0}, 2'd1);
        send_beat(16'd27898, 24'h5D2300);
        i_valid <= 0;
        for (int o = 0; o < 4; o++) begin
            set_coeffs(CAL_A, CAL_B, CAL_T, 2'(o));
            send_beat(16'd27898, 24'h5D2300);
            send_beat(16'h0000, 24'h000000);
            send_beat(16'hFFFF, 24'hFFFFFF);
            send_beat(16'h0000, 24'hFFFFFF);
            i_valid <= 0;
        end
        set_coeffs('1, '1, '1, 2'd3);
        send_beat(16'hFFFF, 24'hFFFFFF);
        send_beat(16'h0000, 24'h000000);
        i_valid <= 0;

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin send_idle_pct = 51; rx_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rx_stall_pct = 51; end
                default: begin send_idle_pct = 31; rx_stall_pct = 31; end
            endcase
            if (ph == 5)
                set_coeffs({$urandom, $urandom}, $urandom, {$urandom, $urandom},
                           2'($urandom));
            else if (ph == 7)
                set_coeffs('1, '1, '1, 2'd3);
            else
                set_coeffs(jitter64(CAL_A), CAL_B ^ {6'd0, 10'($urandom), 6'd0,
                           10'($urandom)}, jitter64(CAL_T), 2'(ph));
            if (ph == 2) begin
                hold_go <= 1;
                @(posedge i_clk);
                hold_go <= 0;
            end
            send_random(100);
            // sender pause until everything is back
            while (pending != 0) @(posedge i_clk);
            send_random(110);
        end

        send_idle_pct = 0;
        rx_stall_pct = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/bca_pkg.sv
hw/rtl/bca_div.sv
hw/rtl/bca_ring.sv
hw/rtl/baro_compensate_avg.sv
tb/sv/baro_compensate_avg_check.sv
tb/sv/baro_compensate_avg_test.sv
